[sv/life_like_automaton_grid_macros.svh]
// Assertion macros used by the life-like automaton grid datapath
`ifndef LIFE_LIKE_AUTOMATON_GRID_MACROS_SVH
`define LIFE_LIKE_AUTOMATON_GRID_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define LLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define LLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lla_pkg.sv]
// Types, constants and helper functions of the life-like automaton grid
package lla_pkg;

    localparam int GRID_SIDE = 64;
    localparam int ROW_W     = $clog2(GRID_SIDE);
    localparam int ROT_W     = GRID_SIDE + 1;
    localparam int FIELD_W   = 6;
    localparam int LIVE_W    = 13;
    localparam int GEN_W     = 32;
    localparam int CFG_W     = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [LIVE_W-1:0] LIVE_MAX = {LIVE_W{1'b1}};
    localparam logic [GRID_SIDE-1:0] BORDER_MASK =
        (GRID_SIDE'(1) << (GRID_SIDE - 1)) | GRID_SIDE'(1);
    localparam logic [ROW_W-1:0] COL_LAST = ROW_W'(GRID_SIDE - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_SIDE - 2);

    localparam logic [CFG_W-1:0] SURVIVE_ABOVE_RST   = CFG_W'(2);
    localparam logic [CFG_W-1:0] DIE_AT_OR_ABOVE_RST = CFG_W'(6);
    localparam logic [CFG_W-1:0] BIRTH_MIN_RST       = CFG_W'(3);
    localparam logic [CFG_W-1:0] BIRTH_MAX_RST       = CFG_W'(3);

    typedef enum logic [1:0] {
        CMD_TOGGLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_STEP   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SURVIVE_ABOVE   = 2'd0,
        REG_DIE_AT_OR_ABOVE = 2'd1,
        REG_BIRTH_MIN       = 2'd2,
        REG_BIRTH_MAX       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        RD_CELL,
        RD_FIRST,
        RD_NEXT
    } t_rd_src;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_STEP_INIT,
        ST_STEP_MID,
        ST_FETCH,
        ST_LOAD,
        ST_CELL,
        ST_WRITE,
        ST_FINISH,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [FIELD_W-1:0] cell_row;
        logic [FIELD_W-1:0] cell_col;
    } t_in_beat;

    typedef struct packed {
        logic              cell_value;
        logic [LIVE_W-1:0] population;
        logic [GEN_W-1:0]  generation;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_W-1:0] survive_above;
        logic [CFG_W-1:0] die_at_or_above;
        logic [CFG_W-1:0] birth_min;
        logic [CFG_W-1:0] birth_max;
    } t_rules;

    typedef struct packed {
        logic    latch;
        logic    clr;
        logic    rd_en;
        t_rd_src rd_src;
        logic    step_init;
        logic    load_mid;
        logic    load_below;
        logic    cell_en;
        logic    row_write;
        logic    fin;
        logic    resp;
    } t_dp_cmd;

    typedef struct packed {
        logic col_last;
        logic row_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic in_grid(input logic [FIELD_W-1:0] v);
        return int'(v) < GRID_SIDE;
    endfunction

    function automatic logic [ROT_W-1:0] load_row(input logic [GRID_SIDE-1:0] row);
        return {row & ~BORDER_MASK, 1'b0};
    endfunction

    function automatic logic [ROT_W-1:0] rot(input logic [ROT_W-1:0] x);
        return {x[0], x[ROT_W-1:1]};
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] sum;
        sum = '0;
        for (int k = 0; k < 8; k++) begin
            sum = sum + 4'(v[k]);
        end
        return sum;
    endfunction

endpackage

[sv/lla_regs.sv]
// APB register file holding the birth and survival rules
module lla_regs import lla_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_rules             o_rules
);

    t_rules   r_rules;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx   = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr    = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_rules = r_rules;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rules.survive_above   <= SURVIVE_ABOVE_RST;
            r_rules.die_at_or_above <= DIE_AT_OR_ABOVE_RST;
            r_rules.birth_min       <= BIRTH_MIN_RST;
            r_rules.birth_max       <= BIRTH_MAX_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_SURVIVE_ABOVE:   r_rules.survive_above   <= pwdata[CFG_W-1:0];
                REG_DIE_AT_OR_ABOVE: r_rules.die_at_or_above <= pwdata[CFG_W-1:0];
                REG_BIRTH_MIN:       r_rules.birth_min       <= pwdata[CFG_W-1:0];
                REG_BIRTH_MAX:       r_rules.birth_max       <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SURVIVE_ABOVE:   prdata = PDATA_W'(r_rules.survive_above);
            REG_DIE_AT_OR_ABOVE: prdata = PDATA_W'(r_rules.die_at_or_above);
            REG_BIRTH_MIN:       prdata = PDATA_W'(r_rules.birth_min);
            REG_BIRTH_MAX:       prdata = PDATA_W'(r_rules.birth_max);
            default:             prdata = '0;
        endcase
    end

endmodule

[sv/lla_ctrl.sv]
// Command sequencer of the life-like automaton grid
module lla_ctrl import lla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_in_cmd,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_STEP:  n_state = ST_STEP_INIT;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_READ;
                    endcase
                end
            end
            ST_CLEAR:     n_state = ST_READ;
            ST_STEP_INIT: n_state = ST_STEP_MID;
            ST_STEP_MID:  n_state = ST_FETCH;
            ST_FETCH:     n_state = ST_LOAD;
            ST_LOAD:      n_state = ST_CELL;
            ST_CELL: begin
                if (i_stat.col_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE:     n_state = i_stat.row_last ? ST_FINISH : ST_FETCH;
            ST_FINISH:    n_state = ST_READ;
            ST_READ:      n_state = ST_RESP;
            ST_RESP: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_src = RD_CELL;
        o_in_stall   = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:      o_cmd.latch = i_in_valid;
            ST_CLEAR:     o_cmd.clr = 1'b1;
            ST_STEP_INIT: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_src    = RD_FIRST;
                o_cmd.step_init = 1'b1;
            end
            ST_STEP_MID:  o_cmd.load_mid = 1'b1;
            ST_FETCH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_NEXT;
            end
            ST_LOAD:      o_cmd.load_below = 1'b1;
            ST_CELL:      o_cmd.cell_en = 1'b1;
            ST_WRITE:     o_cmd.row_write = 1'b1;
            ST_FINISH:    o_cmd.fin = 1'b1;
            ST_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_CELL;
            end
            ST_RESP:      o_cmd.resp = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

[sv/lla_dp.sv]
// Grid memory, neighbor window, counters and result register
`include "life_like_automaton_grid_macros.svh"

module lla_dp import lla_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_beat  i_in_data,
    input  t_rules    i_rules,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic [GRID_SIDE-1:0] r_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] r_row_vld;
    logic [GRID_SIDE-1:0] r_rd_data;
    logic                 r_rd_vld;
    t_in_beat             r_beat;
    logic [ROT_W-1:0]     r_above;
    logic [ROT_W-1:0]     r_mid;
    logic [ROT_W-1:0]     r_below;
    logic [GRID_SIDE-1:0] r_next;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     r_col;
    logic [LIVE_W-1:0]    r_pop;
    logic [LIVE_W-1:0]    r_live;
    logic [GEN_W-1:0]     r_gen;
    logic                 r_out_valid;
    t_out_beat            r_out_data;

    logic [ROW_W-1:0]     w_cell_row;
    logic [ROW_W-1:0]     w_cell_col;
    logic                 w_inside;
    logic [GRID_SIDE-1:0] w_rd_row;
    logic [GRID_SIDE-1:0] w_shifted;
    logic                 w_old_bit;
    logic                 w_is_toggle;
    logic [ROW_W-1:0]     w_next_addr;
    logic                 w_next_border;
    logic [ROW_W-1:0]     w_rd_addr;
    logic                 w_out_free;
    logic                 w_mem_we;
    logic [ROW_W-1:0]     w_wr_addr;
    logic [GRID_SIDE-1:0] w_wr_data;
    logic [3:0]           w_nbr;
    logic                 w_alive;
    logic                 w_inner;
    logic                 w_new;

    assign w_cell_row    = ROW_W'(r_beat.cell_row);
    assign w_cell_col    = ROW_W'(r_beat.cell_col);
    assign w_inside      = in_grid(r_beat.cell_row) && in_grid(r_beat.cell_col);
    assign w_rd_row      = r_rd_vld ? r_rd_data : '0;
    assign w_shifted     = w_rd_row >> w_cell_col;
    assign w_old_bit     = w_shifted[0];
    assign w_is_toggle   = (r_beat.cmd == CMD_TOGGLE);
    assign w_next_addr   = r_row + ROW_W'(1);
    assign w_next_border = (w_next_addr == COL_LAST);
    assign w_out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.rd_src)
            RD_CELL:  w_rd_addr = w_cell_row;
            RD_FIRST: w_rd_addr = ROW_W'(1);
            RD_NEXT:  w_rd_addr = w_next_addr;
            default:  w_rd_addr = w_cell_row;
        endcase
    end

    assign w_mem_we  = i_cmd.row_write ||
                       (i_cmd.resp && w_out_free && w_is_toggle && w_inside);
    assign w_wr_addr = i_cmd.row_write ? r_row : w_cell_row;
    assign w_wr_data = i_cmd.row_write ? r_next :
                       (w_rd_row ^ (GRID_SIDE'(1) << w_cell_col));

    assign w_nbr   = popcount8({r_above[2:0], r_mid[2], r_mid[0], r_below[2:0]});
    assign w_alive = r_mid[1];
    assign w_inner = (r_col != '0) && (r_col != COL_LAST);
    assign w_new   = w_inner && (w_alive ?
                     ((w_nbr > i_rules.survive_above) && (w_nbr < i_rules.die_at_or_above)) :
                     ((w_nbr >= i_rules.birth_min) && (w_nbr <= i_rules.birth_max)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_row_vld[w_rd_addr];
        end
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.clr) begin
            r_row_vld <= '0;
        end else if (i_cmd.fin) begin
            r_row_vld[0]           <= 1'b0;
            r_row_vld[GRID_SIDE-1] <= 1'b0;
        end else if (w_mem_we) begin
            r_row_vld[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_beat <= i_in_data;
        end
        if (i_cmd.step_init) begin
            r_above <= '0;
            r_pop   <= '0;
        end
        if (i_cmd.load_mid) begin
            r_mid <= load_row(w_rd_row);
            r_row <= ROW_W'(1);
        end
        if (i_cmd.load_below) begin
            r_below <= w_next_border ? '0 : load_row(w_rd_row);
            r_col   <= '0;
        end
        if (i_cmd.cell_en) begin
            r_above <= rot(r_above);
            r_mid   <= rot(r_mid);
            r_below <= rot(r_below);
            r_next  <= {w_new, r_next[GRID_SIDE-1:1]};
            if (r_col != COL_LAST) begin
                r_col <= r_col + ROW_W'(1);
            end
            if (w_alive && (r_pop != LIVE_MAX)) begin
                r_pop <= r_pop + LIVE_W'(1);
            end
        end
        if (i_cmd.row_write) begin
            r_above <= rot(r_mid);
            r_mid   <= rot(r_below);
            r_row   <= w_next_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_gen  <= '0;
        end else if (i_cmd.clr) begin
            r_live <= '0;
            r_gen  <= '0;
        end else if (i_cmd.fin) begin
            r_live <= r_pop;
            r_gen  <= r_gen + GEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp && w_out_free) begin
            r_out_data.cell_value <= w_inside && (w_old_bit ^ w_is_toggle);
            r_out_data.population <= r_live;
            r_out_data.generation <= r_gen;
        end
    end

    assign o_stat.col_last = (r_col == COL_LAST);
    assign o_stat.row_last = (r_row == ROW_LAST);
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

    `LLA_ASSERT_NOW(a_fin_after_last_row, i_cmd.fin, r_row == COL_LAST, "step ended before the last row")
    `LLA_ASSERT_NEXT(a_resp_loads_out, i_cmd.resp && w_out_free, r_out_valid, "result beat lost")
    `LLA_ASSERT_NEXT(a_gen_hold, !i_cmd.fin && !i_cmd.clr, $stable(r_gen), "generation moved")

endmodule

[sv/life_like_automaton_grid.sv]
// Top level of the life-like automaton grid: rules, sequencer and grid datapath
//
//   channel  direction  handshake                 payload
//   in       in         i_in_valid / o_in_stall   i_in_data  (t_in_beat)
//   out      out        o_out_valid / i_out_stall o_out_data (t_out_beat)
//   cfg      in         psel / penable / pready   paddr, pwdata, prdata
//
// Result beats queue in one output register.
// Step runs one cell per cycle along each row, with fetch, load and write states between
// rows, through a three-row window fed by the row memory.
// Reset and clear drop per-row valid flags at once; no clearing pass.
// A stalled result holds the sequencer in its response state.
module life_like_automaton_grid import lla_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_rules   w_rules;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lla_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rules (w_rules)
    );

    lla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    lla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_rules     (w_rules),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
